[src/ispc_pkg.sv]
// ----------------------------------------------------------------------------
// ispc_pkg
// Shared types and codes for the interval set point coalescer.
// ----------------------------------------------------------------------------
package ispc_pkg;

    localparam int unsigned DataW      = 32;
    localparam int unsigned StatusW    = 3;
    localparam int unsigned MaxResults = 32;
    localparam int unsigned OutDataW   = 72;

    localparam logic [StatusW-1:0] ST_INSERTED = 3'd0;
    localparam logic [StatusW-1:0] ST_DUP      = 3'd1;
    localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
    localparam logic [StatusW-1:0] ST_RANGE    = 3'd3;
    localparam logic [StatusW-1:0] ST_EMPTY    = 3'd4;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD    = 3'd0,
        OP_CAPTURE = 3'd1,
        OP_ROTATE  = 3'd2,
        OP_FUSE    = 3'd3,
        OP_JLO     = 3'd4,
        OP_JHI     = 3'd5,
        OP_NEW     = 3'd6
    } t_op;

    typedef struct packed {
        logic signed [DataW-1:0] start;
        logic signed [DataW-1:0] stop;
        logic                    valid;
        logic                    le;
    } t_link;

    typedef struct packed {
        logic prev;
        logic next;
        logic dup;
        logic jlo;
        logic jhi;
    } t_flag;

endpackage

[src/ispc_cell.sv]
// ----------------------------------------------------------------------------
// ispc_cell
// One range slot of the sorted chain: compares against the pending value and
// shifts, merges or rotates with its neighbors.
// ----------------------------------------------------------------------------
module ispc_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ispc_pkg::t_op                    i_op,
    input  logic signed [ispc_pkg::DataW-1:0] i_value,
    input  ispc_pkg::t_link                  i_left,
    input  ispc_pkg::t_link                  i_right,
    input  ispc_pkg::t_link                  i_head,
    output ispc_pkg::t_link                  o_link,
    output ispc_pkg::t_flag                  o_flag
);

    logic signed [ispc_pkg::DataW-1:0] r_start, n_start;
    logic signed [ispc_pkg::DataW-1:0] r_stop, n_stop;
    logic                              r_valid, n_valid;
    logic                              r_le, r_cont, r_alo, r_ahi;
    logic                              at_pos, is_prev, is_tail;
    logic signed [ispc_pkg::DataW:0]   stop_inc, start_dec, value_x;

    assign at_pos  = !r_le && i_left.le;
    assign is_prev = r_le && !i_right.le;
    assign is_tail = r_valid && !i_right.valid;

    assign value_x   = {i_value[ispc_pkg::DataW-1], i_value};
    assign stop_inc  = {r_stop[ispc_pkg::DataW-1], r_stop} + (ispc_pkg::DataW + 1)'(1);
    assign start_dec = {r_start[ispc_pkg::DataW-1], r_start} - (ispc_pkg::DataW + 1)'(1);

    always_comb begin
        n_start = r_start;
        n_stop  = r_stop;
        n_valid = r_valid;
        case (i_op)
            ispc_pkg::OP_ROTATE: begin
                if (is_tail) begin
                    n_start = i_head.start;
                    n_stop  = i_head.stop;
                end else if (r_valid) begin
                    n_start = i_right.start;
                    n_stop  = i_right.stop;
                end
            end
            ispc_pkg::OP_FUSE: begin
                if (is_prev) begin
                    n_stop = i_right.stop;
                end else if (!r_le && r_valid) begin
                    n_start = i_right.start;
                    n_stop  = i_right.stop;
                    n_valid = i_right.valid;
                end
            end
            ispc_pkg::OP_JLO: begin
                if (is_prev) n_stop = i_value;
            end
            ispc_pkg::OP_JHI: begin
                if (at_pos && r_valid) n_start = i_value;
            end
            ispc_pkg::OP_NEW: begin
                if (at_pos) begin
                    n_start = i_value;
                    n_stop  = i_value;
                    n_valid = 1'b1;
                end else if (!r_le) begin
                    n_start = i_left.start;
                    n_stop  = i_left.stop;
                    n_valid = i_left.valid;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_stop  <= n_stop;
        if (i_op == ispc_pkg::OP_CAPTURE) begin
            r_cont <= r_stop >= i_value;
            r_alo  <= stop_inc == value_x;
            r_ahi  <= start_dec == value_x;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_le    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_op == ispc_pkg::OP_CAPTURE) begin
                r_le <= r_valid && (r_start <= i_value);
            end
        end
    end

    assign o_link.start = r_start;
    assign o_link.stop  = r_stop;
    assign o_link.valid = r_valid;
    assign o_link.le    = r_le;

    assign o_flag.prev = is_prev;
    assign o_flag.next = at_pos && r_valid;
    assign o_flag.dup  = is_prev && r_cont;
    assign o_flag.jlo  = is_prev && r_alo;
    assign o_flag.jhi  = at_pos && r_valid && r_ahi;

endmodule

[src/interval_set_point_coalescer_top.sv]
// ----------------------------------------------------------------------------
// interval_set_point_coalescer_top
// Sorted table of disjoint integer ranges held in a chain of range cells.
// ----------------------------------------------------------------------------
// Insert: after acceptance the request passes a compare state, then an update
//   state that waits while the output is stalled; the next item is taken in idle.
// Dump: one stored range per cycle while the output is not stalled (the chain
//   rotates once through all ranges), results limited to the lowest 32.
// Reset (synchronous, active low) empties the table and the output register.
module interval_set_point_coalescer_top #(
    parameter int unsigned MAX_RANGES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ispc_pkg::DataW-1:0]      i_s_tdata,  // [31:0] value
    input  logic                            i_s_tuser,  // [0] req_type
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ispc_pkg::OutDataW-1:0]   o_m_tdata,  // [2:0] status, [34:3] range_low,
                                                        // [66:35] range_high, [71:67] zero
    output logic                            o_m_tlast   // last
);

    localparam int unsigned CntW = $clog2(MAX_RANGES + 1);
    localparam int unsigned Lim  = (MAX_RANGES < ispc_pkg::MaxResults) ?
                                   MAX_RANGES : ispc_pkg::MaxResults;
    localparam int unsigned PadW = ispc_pkg::OutDataW - ispc_pkg::StatusW
                                   - 2 * ispc_pkg::DataW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_DUMP = 4'b1000
    } t_state;

    t_state                            r_state, n_state;
    logic signed [ispc_pkg::DataW-1:0] r_value;
    logic [CntW-1:0]                   r_cnt, n_cnt;
    logic [CntW-1:0]                   r_didx, n_didx;
    logic                              r_m_valid, n_m_valid;
    logic [ispc_pkg::StatusW-1:0]      r_status, n_status;
    logic signed [ispc_pkg::DataW-1:0] r_low, n_low, r_high, n_high;
    logic                              r_last, n_last;
    ispc_pkg::t_op                     op;

    ispc_pkg::t_link                   links [MAX_RANGES];
    ispc_pkg::t_flag                   flags [MAX_RANGES];
    ispc_pkg::t_link                   left_edge, right_edge;

    logic                              any_dup, any_jlo, any_jhi;
    logic signed [ispc_pkg::DataW-1:0] prev_start, prev_stop, next_stop;
    logic                              out_free, full;
    logic [CntW-1:0]                   emit_n;

    assign left_edge  = '{start: '0, stop: '0, valid: 1'b0, le: 1'b1};
    assign right_edge = '{start: '0, stop: '0, valid: 1'b0, le: 1'b0};

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        ispc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (op),
            .i_value (r_value),
            .i_left  ((g == 0) ? left_edge : links[(g == 0) ? 0 : g - 1]),
            .i_right ((g == MAX_RANGES - 1) ? right_edge :
                      links[(g == MAX_RANGES - 1) ? g : g + 1]),
            .i_head  (links[0]),
            .o_link  (links[g]),
            .o_flag  (flags[g])
        );
    end

    always_comb begin
        any_dup    = 1'b0;
        any_jlo    = 1'b0;
        any_jhi    = 1'b0;
        prev_start = '0;
        prev_stop  = '0;
        next_stop  = '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
            any_dup    = any_dup | flags[k].dup;
            any_jlo    = any_jlo | flags[k].jlo;
            any_jhi    = any_jhi | flags[k].jhi;
            prev_start = prev_start | (links[k].start & {ispc_pkg::DataW{flags[k].prev}});
            prev_stop  = prev_stop  | (links[k].stop  & {ispc_pkg::DataW{flags[k].prev}});
            next_stop  = next_stop  | (links[k].stop  & {ispc_pkg::DataW{flags[k].next}});
        end
    end

    assign out_free = !r_m_valid || i_m_tready;
    assign full     = links[MAX_RANGES-1].valid;
    assign emit_n   = (r_cnt < CntW'(Lim)) ? r_cnt : CntW'(Lim);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_didx    = r_didx;
        n_m_valid = r_m_valid && !i_m_tready;
        n_status  = r_status;
        n_low     = r_low;
        n_high    = r_high;
        n_last    = r_last;
        op        = ispc_pkg::OP_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_didx  = '0;
                    n_state = (i_s_tuser == ispc_pkg::REQ_DUMP) ? S_DUMP : S_CMP;
                end
            end
            S_CMP: begin
                op      = ispc_pkg::OP_CAPTURE;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_last    = 1'b1;
                    n_status  = ispc_pkg::ST_INSERTED;
                    n_state   = S_IDLE;
                    if (any_dup) begin
                        n_status = ispc_pkg::ST_DUP;
                        n_low    = prev_start;
                        n_high   = prev_stop;
                    end else if (any_jlo && any_jhi) begin
                        op     = ispc_pkg::OP_FUSE;
                        n_cnt  = r_cnt - CntW'(1);
                        n_low  = prev_start;
                        n_high = next_stop;
                    end else if (any_jlo) begin
                        op     = ispc_pkg::OP_JLO;
                        n_low  = prev_start;
                        n_high = r_value;
                    end else if (any_jhi) begin
                        op     = ispc_pkg::OP_JHI;
                        n_low  = r_value;
                        n_high = next_stop;
                    end else if (full) begin
                        n_status = ispc_pkg::ST_FULL;
                        n_low    = '0;
                        n_high   = '0;
                    end else begin
                        op     = ispc_pkg::OP_NEW;
                        n_cnt  = r_cnt + CntW'(1);
                        n_low  = r_value;
                        n_high = r_value;
                    end
                end
            end
            S_DUMP: begin
                if (r_cnt == '0) begin
                    if (out_free) begin
                        n_m_valid = 1'b1;
                        n_status  = ispc_pkg::ST_EMPTY;
                        n_low     = '0;
                        n_high    = '0;
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else if (r_didx >= emit_n || out_free) begin
                    op     = ispc_pkg::OP_ROTATE;
                    n_didx = r_didx + CntW'(1);
                    if (r_didx < emit_n) begin
                        n_m_valid = 1'b1;
                        n_status  = ispc_pkg::ST_RANGE;
                        n_low     = links[0].start;
                        n_high    = links[0].stop;
                        n_last    = (r_didx == emit_n - CntW'(1));
                    end
                    if (r_didx == r_cnt - CntW'(1)) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) r_value <= i_s_tdata;
        r_status <= n_status;
        r_low    <= n_low;
        r_high   <= n_high;
        r_last   <= n_last;
        r_didx   <= n_didx;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{PadW{1'b0}}, r_high, r_low, r_status};
    assign o_m_tlast  = r_last;

endmodule

[src/ispc_checker.sv]
// ----------------------------------------------------------------------------
// ispc_checker
// Port-level checks on the result stream of the coalescer.
// ----------------------------------------------------------------------------
module ispc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ispc_pkg::OutDataW-1:0] o_m_tdata,
    input logic                          o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == ispc_pkg::ST_INSERTED ||
                       o_m_tdata[2:0] == ispc_pkg::ST_DUP ||
                       o_m_tdata[2:0] == ispc_pkg::ST_FULL ||
                       o_m_tdata[2:0] == ispc_pkg::ST_EMPTY) |-> o_m_tlast)
        else $error("single-result transaction without last");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] == ispc_pkg::ST_FULL ||
                       o_m_tdata[2:0] == ispc_pkg::ST_EMPTY) |-> o_m_tdata[66:3] == '0)
        else $error("drop or empty result carries a range");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2:0] != ispc_pkg::ST_FULL &&
        o_m_tdata[2:0] != ispc_pkg::ST_EMPTY |->
        $signed(o_m_tdata[34:3]) <= $signed(o_m_tdata[66:35]))
        else $error("range low above range high");

endmodule

bind interval_set_point_coalescer_top ispc_checker u_ispc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

[dv/tb_interval_set_point_coalescer_top.sv]
// ----------------------------------------------------------------------------
// tb_interval_set_point_coalescer_top
// Self-checking bench for the range table: a directed table of boundary inserts
// and dumps, a fill-to-capacity burst, then random inserts and dumps under four
// handshake mixes, each result checked against the directed plan or a local range model.
// ----------------------------------------------------------------------------
module tb_interval_set_point_coalescer_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH    = 32;
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned MIX_ITEMS      = 18;
    localparam int unsigned DIRECTED_ROWS  = 22;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam logic [31:0] WINDOW_BASE    = 32'd5000;
    localparam logic [31:0] INT_MIN        = 32'h8000_0000;
    localparam logic [31:0] INT_MAX        = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [ispc_pkg::StatusW-1:0]      status;
        logic signed [ispc_pkg::DataW-1:0] lo;
        logic signed [ispc_pkg::DataW-1:0] hi;
        logic                              last;
    } t_result;

    typedef struct {
        logic        req;
        logic [31:0] value;
        bit          typed;
        t_result     res;
    } t_plan_row;

    logic                          i_clk;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [ispc_pkg::DataW-1:0]    i_s_tdata  = '0;   // [31:0] value
    logic                          i_s_tuser  = 1'b0; // [0] req_type
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [ispc_pkg::OutDataW-1:0] o_m_tdata;         // [2:0] status, [34:3] range_low,
                                                      // [66:35] range_high, [71:67] zero
    logic                          o_m_tlast;

    logic signed [ispc_pkg::DataW-1:0] set_lo [TABLE_DEPTH];
    logic signed [ispc_pkg::DataW-1:0] set_hi [TABLE_DEPTH];
    int unsigned                       set_count = 0;

    t_result     replies_due [$];
    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned dumps_sent     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned status_tally [8];

    int unsigned idle_mix  [4] = '{0, 78, 0, 17};
    int unsigned stall_mix [4] = '{0, 0, 78, 17};

    t_plan_row dir_plan [DIRECTED_ROWS] = '{
        '{ispc_pkg::REQ_DUMP,   32'h0000_0000, 1'b1,
          '{ispc_pkg::ST_EMPTY,    32'h0, 32'h0, 1'b1}},
        '{ispc_pkg::REQ_INSERT, INT_MIN,       1'b1,
          '{ispc_pkg::ST_INSERTED, INT_MIN, INT_MIN, 1'b1}},
        '{ispc_pkg::REQ_INSERT, INT_MAX,       1'b1,
          '{ispc_pkg::ST_INSERTED, INT_MAX, INT_MAX, 1'b1}},
        '{ispc_pkg::REQ_INSERT, INT_MIN,       1'b1,
          '{ispc_pkg::ST_DUP,      INT_MIN, INT_MIN, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h8000_0001, 1'b1,
          '{ispc_pkg::ST_INSERTED, INT_MIN, 32'h8000_0001, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h7FFF_FFFE, 1'b1,
          '{ispc_pkg::ST_INSERTED, 32'h7FFF_FFFE, INT_MAX, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_000A, 1'b1,
          '{ispc_pkg::ST_INSERTED, 32'hA, 32'hA, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_000C, 1'b1,
          '{ispc_pkg::ST_INSERTED, 32'hC, 32'hC, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_000B, 1'b1,
          '{ispc_pkg::ST_INSERTED, 32'hA, 32'hC, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_000B, 1'b1,
          '{ispc_pkg::ST_DUP,      32'hA, 32'hC, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'hFFFF_FFFF, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_0001, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_0000, 1'b1,
          '{ispc_pkg::ST_INSERTED, 32'hFFFF_FFFF, 32'h1, 1'b1}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_0009, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h0000_000D, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h8000_0003, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h8000_0002, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h7FFF_FFFC, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'h5555_5555, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_INSERT, 32'hAAAA_AAAA, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_DUMP,   32'h0000_0000, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}},
        '{ispc_pkg::REQ_DUMP,   32'hFFFF_FFFF, 1'b0,
          '{ispc_pkg::ST_INSERTED, 32'h0, 32'h0, 1'b0}}
    };

    interval_set_point_coalescer_top #(
        .MAX_RANGES (TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void post_reply(input logic [ispc_pkg::StatusW-1:0] st,
                                       input logic [31:0] lo,
                                       input logic [31:0] hi, input logic last,
                                       input bit keep);
        t_result r;
        r.status = st;
        r.lo     = lo;
        r.hi     = hi;
        r.last   = last;
        if (keep) replies_due.push_back(r);
    endfunction

    function automatic void coalesce_request(input logic req, input logic [31:0] raw,
                                             input bit keep);
        int unsigned n;
        int unsigned pos;
        int unsigned i;
        longint      a;
        bit          join_lo;
        bit          join_hi;
        if (req == ispc_pkg::REQ_DUMP) begin
            n = (set_count < ispc_pkg::MaxResults) ? set_count : ispc_pkg::MaxResults;
            if (n == 0) post_reply(ispc_pkg::ST_EMPTY, '0, '0, 1'b1, keep);
            for (i = 0; i < n; i++)
                post_reply(ispc_pkg::ST_RANGE, set_lo[i], set_hi[i], i + 1 == n, keep);
            return;
        end
        a = longint'($signed(raw));
        pos = 0;
        while (pos < set_count && longint'(set_lo[pos]) <= a) pos++;
        if (pos > 0 && longint'(set_hi[pos-1]) >= a) begin
            post_reply(ispc_pkg::ST_DUP, set_lo[pos-1], set_hi[pos-1], 1'b1, keep);
            return;
        end
        join_lo = pos > 0 && longint'(set_hi[pos-1]) == a - 1;
        join_hi = pos < set_count && longint'(set_lo[pos]) == a + 1;
        if (join_lo && join_hi) begin
            set_hi[pos-1] = set_hi[pos];
            for (i = pos; i + 1 < set_count; i++) begin
                set_lo[i] = set_lo[i+1];
                set_hi[i] = set_hi[i+1];
            end
            set_count--;
            post_reply(ispc_pkg::ST_INSERTED, set_lo[pos-1], set_hi[pos-1], 1'b1, keep);
        end else if (join_lo) begin
            set_hi[pos-1] = raw;
            post_reply(ispc_pkg::ST_INSERTED, set_lo[pos-1], raw, 1'b1, keep);
        end else if (join_hi) begin
            set_lo[pos] = raw;
            post_reply(ispc_pkg::ST_INSERTED, raw, set_hi[pos], 1'b1, keep);
        end else if (set_count >= TABLE_DEPTH) begin
            post_reply(ispc_pkg::ST_FULL, '0, '0, 1'b1, keep);
        end else begin
            for (i = set_count; i > pos; i--) begin
                set_lo[i] = set_lo[i-1];
                set_hi[i] = set_hi[i-1];
            end
            set_lo[pos] = raw;
            set_hi[pos] = raw;
            set_count++;
            post_reply(ispc_pkg::ST_INSERTED, raw, raw, 1'b1, keep);
        end
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned r;
        int unsigned idx;
        logic [31:0] lo;
        logic [31:0] hi;
        r = $urandom_range(0, 99);
        if (r < 35) return WINDOW_BASE + $urandom_range(0, 47);
        if (r < 65 && set_count > 0) begin
            idx = $urandom_range(0, set_count - 1);
            lo  = set_lo[idx];
            hi  = set_hi[idx];
            case ($urandom_range(0, 5))
                0: return lo - 1;
                1: return hi + 1;
                2: return lo;
                3: return hi;
                4: return lo - 2;
                default: return hi + 2;
            endcase
        end
        if (r < 85) return $urandom;
        if ($urandom_range(0, 1) == 1) return INT_MIN + $urandom_range(0, 3);
        return INT_MAX - $urandom_range(0, 3);
    endfunction

    task automatic send_item(input logic req, input logic [31:0] v, input bit typed,
                             input t_result want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= v;
        i_s_tuser  <= req;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        coalesce_request(req, v, !typed);
        if (typed) replies_due.push_back(want);
        items_sent++;
        if (req == ispc_pkg::REQ_DUMP) dumps_sent++;
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic fill_then_probe();
        logic [31:0] base;
        int unsigned k;
        base = $urandom_range(20000, 200000);
        k = 0;
        while (set_count < TABLE_DEPTH && k < 64) begin
            send_item(ispc_pkg::REQ_INSERT, base + 3 * k, 1'b0, '0);
            k++;
        end
        send_item(ispc_pkg::REQ_DUMP, $urandom, 1'b0, '0);
        send_item(ispc_pkg::REQ_INSERT, base - 1000, 1'b0, '0);
        send_item(ispc_pkg::REQ_INSERT, base + 1, 1'b0, '0);
        send_item(ispc_pkg::REQ_INSERT, base, 1'b0, '0);
        send_item(ispc_pkg::REQ_INSERT, base + 2, 1'b0, '0);
        send_item(ispc_pkg::REQ_DUMP, $urandom, 1'b0, '0);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 99) < 12) send_item(ispc_pkg::REQ_DUMP, $urandom, 1'b0, '0);
        else send_item(ispc_pkg::REQ_INSERT, pick_value(), 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tdata[2:0];
            got.lo     = o_m_tdata[34:3];
            got.hi     = o_m_tdata[66:35];
            got.last   = o_m_tlast;
            status_tally[got.status]++;
            if (replies_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: status %0d low %0d high %0d last %0b",
                             got.status, got.lo, got.hi, got.last);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.lo !== want.lo ||
                    got.hi !== want.hi || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected status %0d low %0d high %0d last %0b, got status %0d low %0d high %0d last %0b",
                                 want.status, want.lo, want.hi, want.last,
                                 got.status, got.lo, got.hi, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction in %0d cycles", QUIET_LIMIT);
            $display("interval_set_point_coalescer_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned row;
        int unsigned mix;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
            send_item(dir_plan[row].req, dir_plan[row].value, dir_plan[row].typed,
                      dir_plan[row].res);
        hold_until_drained();

        for (mix = 0; mix < 4; mix++) begin
            src_idle_pct   = idle_mix[mix];
            sink_stall_pct = stall_mix[mix];
            if (mix == 0) fill_then_probe();
            repeat (MIX_ITEMS) random_item();
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (replies_due.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", replies_due.size());
        end
        $display("sent %0d requests (%0d dumps) across four ready/valid mixes, table filled to %0d",
                 items_sent, dumps_sent, TABLE_DEPTH);
        $display("seen: %0d inserted, %0d duplicate, %0d dropped full, %0d ranges, %0d empty",
                 status_tally[ispc_pkg::ST_INSERTED], status_tally[ispc_pkg::ST_DUP],
                 status_tally[ispc_pkg::ST_FULL], status_tally[ispc_pkg::ST_RANGE],
                 status_tally[ispc_pkg::ST_EMPTY]);
        if (fail_count == 0) begin
            $display("interval_set_point_coalescer_top verification clean");
        end else begin
            $display("interval_set_point_coalescer_top verification failed");
        end
        $finish;
    end

endmodule

[interval_set_point_coalescer_top.f]
src/ispc_pkg.sv
src/ispc_cell.sv
src/interval_set_point_coalescer_top.sv
src/ispc_checker.sv
dv/tb_interval_set_point_coalescer_top.sv
